// ===== src/chs_pkg.sv =====
// ----------------------------------------------------------------------------
// chs_pkg: shared definitions of the chained hash set
// Operation codes, default sizes and helper widths used by all modules but the queue.
// ----------------------------------------------------------------------------
package chs_pkg;

  localparam int DEF_BUCKETS      = 16;
  localparam int DEF_POOL_ENTRIES = 64;

  localparam int OP_W    = 2;
  localparam int KEY_W   = 32;
  localparam int COUNT_W = 7;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

  // Width of an index into n entries, never below one bit.
  function automatic int idx_w(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

// ===== src/chained_hash_set_unit.sv =====
// ----------------------------------------------------------------------------
// chained_hash_set_unit: hash multiset with separate chaining
// Signed keys hash to |key| mod BUCKETS; chains live in a bounded node pool.
// ----------------------------------------------------------------------------
// Sequence: the front reduces the key, then the back carries out the word. Insert
//   goes from S_IDLE to S_HEAD; lookup and delete pass S_HEAD, then S_WALK and
//   S_CMP per chain node visited, ending in S_WALK on a miss; clear walks all heads.
// Pace: the front takes no new word while it reduces one, and it stays full
//   until the queue has taken its word; on short chains that sets the pace.
//   Long chains cost the back a walk and a compare per node; then it sets the pace.
// Reset: synchronous and active high; afterwards a clearing pass empties every
//   bucket head before the first word is carried out.
// ----------------------------------------------------------------------------
module chained_hash_set_unit #(
  parameter int BUCKETS      = chs_pkg::DEF_BUCKETS,
  parameter int POOL_ENTRIES = chs_pkg::DEF_POOL_ENTRIES
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic [chs_pkg::OP_W-1:0]          operation,
  input  logic signed [chs_pkg::KEY_W-1:0]  key,
  output logic                              empty,
  input  logic                              pop,
  output logic                              found,
  output logic                              status,
  output logic [chs_pkg::COUNT_W-1:0]       count
);
  import chs_pkg::*;

  localparam int BW = idx_w(BUCKETS);
  localparam int QW = OP_W + KEY_W + BW;

  // Classified word from the front: operation, raw key and bucket index.
  logic              f_valid, f_take;
  logic [OP_W-1:0]   f_op;
  logic [KEY_W-1:0]  f_key;
  logic [BW-1:0]     f_bucket;

  // Head of the queue as seen by the back.
  logic              b_valid, b_take;
  logic [QW-1:0]     b_data;

  chs_front #(.BUCKETS(BUCKETS), .BW(BW)) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .operation   (operation),
    .key         (key),
    .item_valid  (f_valid),
    .item_take   (f_take),
    .item_op     (f_op),
    .item_key    (f_key),
    .item_bucket (f_bucket)
  );

  // The queue decouples key reduction from the chain walk.
  chs_queue #(.W(QW)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_take   (f_take),
    .in_data   ({f_op, f_key, f_bucket}),
    .out_valid (b_valid),
    .out_take  (b_take),
    .out_data  (b_data)
  );

  // The back owns all table state and the result register.
  chs_back #(.BUCKETS(BUCKETS), .POOL_ENTRIES(POOL_ENTRIES), .BW(BW)) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (b_valid),
    .q_take   (b_take),
    .q_op     (b_data[QW-1 -: OP_W]),
    .q_key    (b_data[BW +: KEY_W]),
    .q_bucket (b_data[BW-1:0]),
    .empty    (empty),
    .pop      (pop),
    .found    (found),
    .status   (status),
    .count    (count)
  );

endmodule

// ===== src/chs_front.sv =====
// ----------------------------------------------------------------------------
// chs_front: input stage of the chained hash set
// Accepts a word and reduces the key magnitude modulo the bucket count,
// eight bits per cycle, then hands the classified word to the queue.
// ----------------------------------------------------------------------------
module chs_front #(
  parameter int BUCKETS = chs_pkg::DEF_BUCKETS,
  parameter int BW      = chs_pkg::idx_w(BUCKETS)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  logic [chs_pkg::OP_W-1:0]  operation,
  input  logic signed [chs_pkg::KEY_W-1:0] key,
  output logic                      item_valid,
  input  logic                      item_take,
  output logic [chs_pkg::OP_W-1:0]  item_op,
  output logic [chs_pkg::KEY_W-1:0] item_key,
  output logic [BW-1:0]             item_bucket
);
  import chs_pkg::*;

  localparam int STEPS = 4;
  localparam int BITS  = KEY_W / STEPS;

  logic                 busy;
  logic [1:0]           step;
  logic [KEY_W-1:0]     mag;
  logic [BW-1:0]        rem;
  logic [BW-1:0]        rem_next;
  logic [KEY_W-1:0]     key_u;

  assign key_u = key;
  assign full  = busy || item_valid;

  // Restoring remainder over the next eight magnitude bits.
  always_comb begin
    logic [BW:0] r;
    r = {1'b0, rem};
    for (int i = 0; i < BITS; i++) begin
      r = {r[BW-1:0], mag[KEY_W-1-i]};
      if (r >= (BW+1)'(BUCKETS)) begin
        r = r - (BW+1)'(BUCKETS);
      end
    end
    rem_next = r[BW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      item_valid <= 1'b0;
      step       <= '0;
    end else begin
      if (push && !full) begin
        busy     <= 1'b1;
        step     <= '0;
        rem      <= '0;
        mag      <= key_u[KEY_W-1] ? (KEY_W'(0) - key_u) : key_u;
        item_op  <= operation;
        item_key <= key_u;
      end else if (busy) begin
        rem  <= rem_next;
        mag  <= mag << BITS;
        step <= step + 2'd1;
        if (step == 2'(STEPS-1)) begin
          busy        <= 1'b0;
          item_valid  <= 1'b1;
          item_bucket <= rem_next;
        end
      end else if (item_valid && item_take) begin
        item_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== src/chs_queue.sv =====
// ----------------------------------------------------------------------------
// chs_queue: two-entry queue between front and back
// Lets the front classify the next word while the back walks a chain.
// ----------------------------------------------------------------------------
module chs_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_take,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  input  logic         out_take,
  output logic [W-1:0] out_data
);
  logic [W-1:0] slots [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   fill;
  logic         do_wr;
  logic         do_rd;

  assign in_take   = in_valid && (fill != 2'd2);
  assign do_wr     = in_take;
  assign out_valid = (fill != 2'd0);
  assign do_rd     = out_valid && out_take;
  assign out_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_wr) begin
        slots[wr_ptr] <= in_data;
        wr_ptr        <= ~wr_ptr;
      end
      if (do_rd) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

endmodule

// ===== src/chs_back.sv =====
// ----------------------------------------------------------------------------
// chs_back: chain engine of the chained hash set
// Walks and edits bucket chains in the head, key and link memories, keeps a
// stack of freed nodes, and holds the result word until it is popped.
// ----------------------------------------------------------------------------
module chs_back #(
  parameter int BUCKETS      = chs_pkg::DEF_BUCKETS,
  parameter int POOL_ENTRIES = chs_pkg::DEF_POOL_ENTRIES,
  parameter int BW           = chs_pkg::idx_w(BUCKETS)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  output logic                         q_take,
  input  logic [chs_pkg::OP_W-1:0]     q_op,
  input  logic [chs_pkg::KEY_W-1:0]    q_key,
  input  logic [BW-1:0]                q_bucket,
  output logic                         empty,
  input  logic                         pop,
  output logic                         found,
  output logic                         status,
  output logic [chs_pkg::COUNT_W-1:0]  count
);
  import chs_pkg::*;

  localparam int PW = idx_w(POOL_ENTRIES);
  localparam int NW = $clog2(POOL_ENTRIES + 1);
  localparam logic [NW-1:0] NIL  = NW'(POOL_ENTRIES);
  localparam logic [NW-1:0] FULL = NW'(POOL_ENTRIES);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_HEAD = 3'd2;
  localparam logic [2:0] S_WALK = 3'd3;
  localparam logic [2:0] S_CMP  = 3'd4;

  logic [NW-1:0]    heads  [BUCKETS];
  logic [KEY_W-1:0] keys   [POOL_ENTRIES];
  logic [NW-1:0]    links  [POOL_ENTRIES];
  logic [PW-1:0]    frees  [POOL_ENTRIES];

  logic [2:0]       state, state_next;
  logic [OP_W-1:0]  op, op_next;
  logic [KEY_W-1:0] key, key_next;
  logic [BW-1:0]    bkt, bkt_next;
  logic [NW-1:0]    cur, cur_next;
  logic [NW-1:0]    prev, prev_next;
  logic [NW-1:0]    sp, sp_next;
  logic [NW-1:0]    hwm, hwm_next;
  logic [NW-1:0]    entries, entries_next;
  logic [BW-1:0]    clr_cnt, clr_cnt_next;
  logic             clr_report, clr_report_next;
  logic             ovalid, ovalid_next;
  logic             found_next, status_next;
  logic [NW-1:0]    ocount, ocount_next;

  logic             hd_we, ln_we, ky_we, fs_we;
  logic [BW-1:0]    hd_wa, hd_ra;
  logic [NW-1:0]    hd_wd, ln_wd, hd_q, ln_q;
  logic [PW-1:0]    ln_wa, ky_wa, fs_wa, nd_ra, fs_ra, fs_q;
  logic [PW-1:0]    fs_wd;
  logic [KEY_W-1:0] ky_q;

  assign empty  = !ovalid;
  assign count  = COUNT_W'(ocount);

  always_comb begin
    state_next      = state;
    op_next         = op;
    key_next        = key;
    bkt_next        = bkt;
    cur_next        = cur;
    prev_next       = prev;
    sp_next         = sp;
    hwm_next        = hwm;
    entries_next    = entries;
    clr_cnt_next    = clr_cnt;
    clr_report_next = clr_report;
    ovalid_next     = ovalid && !pop;
    found_next      = found;
    status_next     = status;
    ocount_next     = ocount;
    q_take = 1'b0;
    hd_we = 1'b0; hd_wa = bkt; hd_wd = NIL; hd_ra = q_bucket;
    ln_we = 1'b0; ln_wa = cur[PW-1:0]; ln_wd = NIL;
    ky_we = 1'b0; ky_wa = cur[PW-1:0];
    fs_we = 1'b0; fs_wa = sp[PW-1:0]; fs_wd = cur[PW-1:0];
    nd_ra = cur[PW-1:0];
    fs_ra = PW'(sp - NW'(1));
    case (state)
      S_CLR: begin
        hd_we = 1'b1;
        hd_wa = clr_cnt;
        clr_cnt_next = clr_cnt + BW'(1);
        if (clr_cnt == BW'(BUCKETS - 1)) begin
          state_next = S_IDLE;
          if (clr_report) begin
            ovalid_next = 1'b1;
            found_next  = 1'b0;
            status_next = 1'b0;
            ocount_next = '0;
          end
        end
      end
      S_IDLE: begin
        if (q_valid && !ovalid) begin
          q_take   = 1'b1;
          op_next  = q_op;
          key_next = q_key;
          bkt_next = q_bucket;
          if (q_op == OP_CLEAR) begin
            state_next      = S_CLR;
            clr_cnt_next    = '0;
            clr_report_next = 1'b1;
            sp_next         = '0;
            hwm_next        = '0;
            entries_next    = '0;
          end else begin
            state_next = S_HEAD;
          end
        end
      end
      S_HEAD: begin
        if (op == OP_INSERT) begin
          state_next  = S_IDLE;
          ovalid_next = 1'b1;
          found_next  = 1'b0;
          status_next = 1'b0;
          if (sp != '0 || hwm != FULL) begin
            if (sp != '0) begin
              ky_wa   = fs_q;
              sp_next = sp - NW'(1);
            end else begin
              ky_wa    = hwm[PW-1:0];
              hwm_next = hwm + NW'(1);
            end
            ky_we = 1'b1;
            ln_we = 1'b1;
            ln_wa = ky_wa;
            ln_wd = hd_q;
            hd_we = 1'b1;
            hd_wd = NW'(ky_wa);
            entries_next = entries + NW'(1);
            ocount_next  = entries + NW'(1);
          end else begin
            status_next = 1'b1;
            ocount_next = entries;
          end
        end else begin
          cur_next   = hd_q;
          prev_next  = NIL;
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        if (cur == NIL) begin
          state_next  = S_IDLE;
          ovalid_next = 1'b1;
          found_next  = 1'b0;
          status_next = 1'b0;
          ocount_next = entries;
        end else begin
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        if (ky_q == key) begin
          state_next  = S_IDLE;
          ovalid_next = 1'b1;
          found_next  = 1'b1;
          status_next = 1'b0;
          ocount_next = entries;
          if (op == OP_DELETE) begin
            if (prev == NIL) begin
              hd_we = 1'b1;
              hd_wd = ln_q;
            end else begin
              ln_we = 1'b1;
              ln_wa = prev[PW-1:0];
              ln_wd = ln_q;
            end
            fs_we        = 1'b1;
            sp_next      = sp + NW'(1);
            entries_next = entries - NW'(1);
            ocount_next  = entries - NW'(1);
          end
        end else begin
          prev_next  = cur;
          cur_next   = ln_q;
          state_next = S_WALK;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      clr_cnt    <= '0;
      clr_report <= 1'b0;
      sp         <= '0;
      hwm        <= '0;
      entries    <= '0;
      ovalid     <= 1'b0;
    end else begin
      state      <= state_next;
      clr_cnt    <= clr_cnt_next;
      clr_report <= clr_report_next;
      sp         <= sp_next;
      hwm        <= hwm_next;
      entries    <= entries_next;
      ovalid     <= ovalid_next;
    end
    op     <= op_next;
    key    <= key_next;
    bkt    <= bkt_next;
    cur    <= cur_next;
    prev   <= prev_next;
    found  <= found_next;
    status <= status_next;
    ocount <= ocount_next;
  end

  always_ff @(posedge clk) begin
    if (hd_we) heads[hd_wa] <= hd_wd;
    if (ln_we) links[ln_wa] <= ln_wd;
    if (ky_we) keys[ky_wa]  <= key;
    if (fs_we) frees[fs_wa] <= fs_wd;
    hd_q <= heads[hd_ra];
    ln_q <= links[nd_ra];
    ky_q <= keys[nd_ra];
    fs_q <= frees[fs_ra];
  end

  // The entry count never passes the pool size.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entries <= NW'(POOL_ENTRIES))
    else $error("entry count beyond pool size");

  // Live plus freed nodes equal the high-water mark whenever the back is idle.
  a_pool_balance: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (entries + sp == hwm))
    else $error("node accounting mismatch");

  // No word is taken from the queue while a result still waits.
  a_take_free: assert property (@(posedge clk) disable iff (rst)
    q_take |-> !ovalid)
    else $error("word taken over a pending result");

  // A new result never overwrites one that was not popped.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (ovalid && !pop) |=> (ovalid && $stable(found) && $stable(count)))
    else $error("pending result lost");

endmodule
